// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the feedback unit RTL.
// Needs clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GLF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("glf assertion failed");

// next-cycle implication
`define GLF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("glf assertion failed");

`endif

// ===== rtl/core/glf_pkg.sv =====
// Types, constants and gain polynomial table for the LQR feedback unit.
// No dependencies.
`timescale 1ns / 1ps
package glf_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int LEN_W      = 16;
  localparam int DATA_W     = 32;
  localparam int NUM_STATES = 6;
  localparam int LANES      = 3;
  localparam int PH_W       = 2;
  localparam int COL_W      = 3;
  localparam int IDX_W      = 4;
  localparam int COEF_W     = 24;

  // coefficient times zero-extended length
  localparam int PROD_W     = COEF_W + LEN_W + 1;
  localparam int SUM_W      = PROD_W + 2;
  localparam int N_W        = SUM_W;
  // gain divisor is 625 * 2^DIV_SHIFT
  localparam int DIV_SHIFT  = 20 - FRAC_BITS;
  localparam int NP_W       = N_W - DIV_SHIFT;
  localparam int A_W        = NP_W - 8;
  localparam int RECIP_W    = 31;
  localparam int Q_W        = A_W + RECIP_W - 32;
  localparam int M_W        = Q_W + 10;
  localparam int GAIN_W     = 29;
  localparam int XP_W       = GAIN_W + DATA_W;
  localparam int ACC_W      = 64;

  localparam logic [N_W-1:0]     RND_HALF = N_W'(5000);
  localparam logic [RECIP_W-1:0] RECIP    = 31'd1759218604;
  localparam logic [M_W-1:0]     DIV_LO   = M_W'(625);
  localparam logic [M_W-1:0]     DIV_LO2  = M_W'(1250);
  localparam logic [PH_W-1:0]    PH_LAST  = 2'd3;

  typedef logic [LEN_W-1:0]         len_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [GAIN_W-1:0] gain_t;

  typedef struct packed {
    coef_t c3;
    coef_t c2;
    coef_t c1;
    coef_t c0;
  } poly_t;

  typedef struct packed {
    len_t                                l1;
    len_t                                l2;
    len_t                                l3;
    logic                                side;
    logic [NUM_STATES-1:0][DATA_W-1:0]   x;
  } item_t;

  typedef struct packed {
    data_t drive_0;
    data_t drive_1;
    logic  side_tag;
  } res_t;

  // cubic coefficients in units of 1e-4, gain index row-major 2x6
  function automatic poly_t glf_poly(input logic [IDX_W-1:0] idx);
    poly_t p;
    case (idx)
      4'd0:    p = '{-24'sd6310761,  24'sd2852972, -24'sd300604,  24'sd40503};
      4'd1:    p = '{ 24'sd203849,  -24'sd120844,   24'sd39481,   24'sd2329};
      4'd2:    p = '{ 24'sd166077,  -24'sd106351,   24'sd25092,   24'sd2674};
      4'd3:    p = '{ 24'sd349595,  -24'sd211920,   24'sd47289,   24'sd5742};
      4'd4:    p = '{-24'sd2618351,  24'sd1753150, -24'sd499900,  24'sd73890};
      4'd5:    p = '{-24'sd133726,   24'sd91519,   -24'sd26463,   24'sd4221};
      4'd6:    p = '{ 24'sd4101481, -24'sd2205179,  24'sd475906, -24'sd64529};
      4'd7:    p = '{ 24'sd272424,  -24'sd190052,   24'sd60616,  -24'sd11553};
      4'd8:    p = '{ 24'sd253229,  -24'sd196293,   24'sd65039,  -24'sd10551};
      4'd9:    p = '{ 24'sd631864,  -24'sd469804,   24'sd146329, -24'sd22218};
      4'd10:   p = '{ 24'sd5855012, -24'sd3730637,  24'sd878715,  24'sd78268};
      4'd11:   p = '{ 24'sd306295,  -24'sd190308,   24'sd43894,   24'sd3245};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/glf_if.sv =====
// Handshake interfaces for the input and result channels.
// Depends on glf_pkg.
`timescale 1ns / 1ps
interface glf_in_if;
  logic           valid;
  logic           ready;
  glf_pkg::len_t  strut_len;
  logic           side_sel;
  glf_pkg::data_t feedback_0;
  glf_pkg::data_t feedback_1;
  glf_pkg::data_t feedback_2;
  glf_pkg::data_t feedback_3;
  glf_pkg::data_t feedback_4;
  glf_pkg::data_t feedback_5;

  modport source (output valid, strut_len, side_sel, feedback_0, feedback_1, feedback_2,
                  feedback_3, feedback_4, feedback_5, input ready);
  modport sink (input valid, strut_len, side_sel, feedback_0, feedback_1, feedback_2,
                feedback_3, feedback_4, feedback_5, output ready);
endinterface

interface glf_out_if;
  logic           valid;
  logic           ready;
  glf_pkg::data_t drive_0;
  glf_pkg::data_t drive_1;
  logic           side_tag;

  modport source (output valid, drive_0, drive_1, side_tag, input ready);
  modport sink (input valid, drive_0, drive_1, side_tag, output ready);
endinterface

// ===== rtl/core/glf_front.sv =====
// Front end: accepts a transaction and forms the rounded length powers.
// Depends on glf_pkg and glf_in_if.
`timescale 1ns / 1ps
module glf_front (
  input  logic           clk,
  input  logic           rst_n,
  glf_in_if.sink         in_ch,
  output logic           q_valid,
  input  logic           q_ready,
  output glf_pkg::item_t q_item
);

  logic           shift;
  logic           a_v_r;
  logic           b_v_r;
  glf_pkg::item_t a_item_r;
  glf_pkg::item_t a_item_nxt;
  glf_pkg::item_t b_item_r;
  glf_pkg::item_t b_item_nxt;
  logic [31:0]    sq;
  logic [31:0]    cube;

  // stall both stages only when the head is blocked
  assign shift       = !(b_v_r && !q_ready);
  assign in_ch.ready = shift;
  assign q_valid     = b_v_r;
  assign q_item      = b_item_r;

  always_comb begin
    sq              = 32'(in_ch.strut_len) * 32'(in_ch.strut_len) + 32'd32768;
    a_item_nxt.l1   = in_ch.strut_len;
    a_item_nxt.l2   = sq[31:16];
    a_item_nxt.l3   = '0;
    a_item_nxt.side = in_ch.side_sel;
    a_item_nxt.x[0] = in_ch.feedback_0;
    a_item_nxt.x[1] = in_ch.feedback_1;
    a_item_nxt.x[2] = in_ch.feedback_2;
    a_item_nxt.x[3] = in_ch.feedback_3;
    a_item_nxt.x[4] = in_ch.feedback_4;
    a_item_nxt.x[5] = in_ch.feedback_5;
    cube            = 32'(a_item_r.l2) * 32'(a_item_r.l1) + 32'd32768;
    b_item_nxt      = a_item_r;
    b_item_nxt.l3   = cube[31:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else if (shift) begin
      a_v_r <= in_ch.valid;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      a_item_r <= a_item_nxt;
      b_item_r <= b_item_nxt;
    end
  end

endmodule

// ===== rtl/core/glf_fifo.sv =====
// Small ready/valid queue used between front and back and on the result side.
// No package dependency.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module glf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r;
  logic [PW-1:0]    rp_r;
  logic [CW-1:0]    cnt_r;
  logic             push;
  logic             pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ptr_inc(wp_r);
      if (pop) rp_r <= ptr_inc(rp_r);
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  `GLF_ASSERT_NEXT(a_fill_track, push && !pop, cnt_r == $past(cnt_r) + 1'b1)

endmodule

// ===== rtl/core/glf_back.sv =====
// Back end: schedules the 12 gain cubics over four phases of three lanes,
// forms both row dot products and the saturated drives. Depends on glf_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module glf_back #(
  parameter int OUT_DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  glf_pkg::item_t q_item,
  output logic           res_valid,
  input  logic           res_ready,
  output glf_pkg::res_t  res_data,
  input  logic           out_pop
);

  localparam int CW = $clog2(OUT_DEPTH + 1);
  localparam int LN = glf_pkg::LANES;

  typedef logic signed [glf_pkg::PROD_W-1:0] prod_t;
  typedef logic signed [glf_pkg::SUM_W-1:0]  sum_t;
  typedef logic signed [glf_pkg::XP_W-1:0]   xp_t;
  typedef logic signed [glf_pkg::ACC_W-1:0]  acc_t;

  logic [CW-1:0]                  cred_r;
  logic [CW-1:0]                  cred_nxt;
  logic                           busy_r;
  logic [glf_pkg::PH_W-1:0]       phase_r;
  glf_pkg::item_t                 cur_r;
  logic                           start;

  logic [glf_pkg::COL_W-1:0]      col_c   [LN];
  glf_pkg::poly_t                 poly1_c [LN];
  glf_pkg::poly_t                 poly2_c [LN];
  sum_t                           s_c     [LN];
  logic [glf_pkg::N_W-1:0]        n_c     [LN];
  logic [glf_pkg::A_W+glf_pkg::RECIP_W-1:0] qp_c [LN];
  logic [glf_pkg::M_W-1:0]        rem_c   [LN];
  logic [glf_pkg::Q_W-1:0]        q_c     [LN];
  glf_pkg::gain_t                 gm_c    [LN];

  logic                           s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r;
  logic [glf_pkg::PH_W-1:0]       s1_ph_r, s2_ph_r, s3_ph_r, s4_ph_r, s5_ph_r, s6_ph_r;
  logic                           s1_sd_r, s2_sd_r, s3_sd_r, s4_sd_r, s5_sd_r, s6_sd_r;
  glf_pkg::data_t                 s1_x_r  [LN];
  glf_pkg::data_t                 s2_x_r  [LN];
  glf_pkg::data_t                 s3_x_r  [LN];
  glf_pkg::data_t                 s4_x_r  [LN];
  prod_t                          s1_p3_r [LN];
  prod_t                          s1_p2_r [LN];
  prod_t                          s1_p1_r [LN];
  logic [glf_pkg::NP_W-1:0]       s2_np_r [LN];
  logic                           s2_ng_r [LN];
  logic [glf_pkg::NP_W-1:0]       s3_np_r [LN];
  logic                           s3_ng_r [LN];
  logic [glf_pkg::Q_W-1:0]        s3_q0_r [LN];
  glf_pkg::gain_t                 s4_g_r  [LN];
  xp_t                            s5_p_r  [LN];
  acc_t                           s6_sum_r;
  acc_t                           acc_r;
  acc_t                           tot;
  acc_t                           sum0_r;
  acc_t                           sum1_r;
  logic                           fin_v_r;
  logic                           fin_sd_r;

  function automatic glf_pkg::data_t sat_round(input acc_t v);
    logic signed [glf_pkg::ACC_W-17:0] t;
    acc_t                              w;
    w = v + acc_t'(1 <<< (glf_pkg::FRAC_BITS - 1));
    t = w[glf_pkg::ACC_W-1:glf_pkg::FRAC_BITS];
    if (t > $signed({{(glf_pkg::ACC_W-48){1'b0}}, 32'h7FFF_FFFF}))
      return 32'sh7FFF_FFFF;
    if (t < $signed({{(glf_pkg::ACC_W-48){1'b1}}, 32'h8000_0000}))
      return 32'sh8000_0000;
    return t[31:0];
  endfunction

  // sequencer: one transaction per four phases, next may start on the last
  assign start   = q_valid && (cred_r != '0) && (!busy_r || phase_r == glf_pkg::PH_LAST);
  assign q_ready = start;
  assign cred_nxt = cred_r - CW'(start) + CW'(out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r  <= CW'(OUT_DEPTH);
      busy_r  <= 1'b0;
      phase_r <= '0;
    end else begin
      cred_r <= cred_nxt;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= '0;
      end else if (busy_r) begin
        phase_r <= phase_r + 1'b1;
        if (phase_r == glf_pkg::PH_LAST) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) cur_r <= q_item;
  end

  always_comb begin
    for (int k = 0; k < LN; k++) begin
      col_c[k]   = glf_pkg::COL_W'(int'(phase_r[0]) * LN + k);
      poly1_c[k] = glf_pkg::glf_poly(glf_pkg::IDX_W'(int'(phase_r[1]) * glf_pkg::NUM_STATES
                                                     + int'(col_c[k])));
      poly2_c[k] = glf_pkg::glf_poly(glf_pkg::IDX_W'(int'(s1_ph_r[1]) * glf_pkg::NUM_STATES
                                                     + int'(s1_ph_r[0]) * LN + k));
      s_c[k] = sum_t'(s1_p3_r[k]) + sum_t'(s1_p2_r[k]) + sum_t'(s1_p1_r[k])
             + (sum_t'(poly2_c[k].c0) <<< glf_pkg::LEN_W);
      n_c[k] = (s_c[k] < 0) ? glf_pkg::N_W'(-s_c[k]) : glf_pkg::N_W'(s_c[k]);
      n_c[k] = n_c[k] + glf_pkg::RND_HALF;
      qp_c[k] = (glf_pkg::A_W + glf_pkg::RECIP_W)'(s2_np_r[k][glf_pkg::NP_W-1:8])
              * (glf_pkg::A_W + glf_pkg::RECIP_W)'(glf_pkg::RECIP);
      rem_c[k] = glf_pkg::M_W'(s3_np_r[k]) - glf_pkg::M_W'(s3_q0_r[k]) * glf_pkg::DIV_LO;
      q_c[k] = s3_q0_r[k];
      if (rem_c[k] >= glf_pkg::DIV_LO2) q_c[k] = s3_q0_r[k] + glf_pkg::Q_W'(2);
      else if (rem_c[k] >= glf_pkg::DIV_LO) q_c[k] = s3_q0_r[k] + glf_pkg::Q_W'(1);
      // gain magnitude stays below 2^27 for this coefficient set
      gm_c[k] = glf_pkg::gain_t'(q_c[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      fin_v_r <= 1'b0;
    end else begin
      s1_v_r  <= busy_r;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      s6_v_r  <= s5_v_r;
      fin_v_r <= s6_v_r && (s6_ph_r == glf_pkg::PH_LAST);
    end
  end

  always_ff @(posedge clk) begin
    s1_ph_r <= phase_r;
    s2_ph_r <= s1_ph_r;
    s3_ph_r <= s2_ph_r;
    s4_ph_r <= s3_ph_r;
    s5_ph_r <= s4_ph_r;
    s6_ph_r <= s5_ph_r;
    s1_sd_r <= cur_r.side;
    s2_sd_r <= s1_sd_r;
    s3_sd_r <= s2_sd_r;
    s4_sd_r <= s3_sd_r;
    s5_sd_r <= s4_sd_r;
    s6_sd_r <= s5_sd_r;
    for (int k = 0; k < LN; k++) begin
      s1_p3_r[k] <= prod_t'(poly1_c[k].c3) * prod_t'($signed({1'b0, cur_r.l3}));
      s1_p2_r[k] <= prod_t'(poly1_c[k].c2) * prod_t'($signed({1'b0, cur_r.l2}));
      s1_p1_r[k] <= prod_t'(poly1_c[k].c1) * prod_t'($signed({1'b0, cur_r.l1}));
      s1_x_r[k]  <= $signed(cur_r.x[col_c[k]]);
      s2_np_r[k] <= n_c[k][glf_pkg::N_W-1:glf_pkg::DIV_SHIFT];
      s2_ng_r[k] <= (s_c[k] < 0);
      s2_x_r[k]  <= s1_x_r[k];
      s3_q0_r[k] <= qp_c[k][glf_pkg::A_W+glf_pkg::RECIP_W-1:32];
      s3_np_r[k] <= s2_np_r[k];
      s3_ng_r[k] <= s2_ng_r[k];
      s3_x_r[k]  <= s2_x_r[k];
      s4_g_r[k]  <= s3_ng_r[k] ? -gm_c[k] : gm_c[k];
      s4_x_r[k]  <= s3_x_r[k];
      s5_p_r[k]  <= xp_t'(s4_g_r[k]) * xp_t'(s4_x_r[k]);
    end
    s6_sum_r <= acc_t'(s5_p_r[0]) + acc_t'(s5_p_r[1]) + acc_t'(s5_p_r[2]);
  end

  assign tot = acc_r + s6_sum_r;

  always_ff @(posedge clk) begin
    if (s6_v_r) begin
      acc_r <= s6_ph_r[0] ? tot : s6_sum_r;
      if (s6_ph_r == 2'd1) sum0_r <= tot;
      if (s6_ph_r == glf_pkg::PH_LAST) begin
        sum1_r   <= tot;
        fin_sd_r <= s6_sd_r;
      end
    end
  end

  assign res_valid         = fin_v_r;
  assign res_data.drive_0  = sat_round(sum0_r);
  assign res_data.drive_1  = sat_round(sum1_r);
  assign res_data.side_tag = fin_sd_r;

  `GLF_ASSERT_NOW(a_res_room, res_valid, res_ready)
  `GLF_ASSERT_NOW(a_cred_bound, 1'b1, cred_r <= CW'(OUT_DEPTH))
  `GLF_ASSERT_NEXT(a_phase_step, busy_r && (phase_r != glf_pkg::PH_LAST),
                   busy_r && (phase_r == $past(phase_r) + 2'd1))

endmodule

// ===== rtl/core/gain_scheduled_lqr_feedback_unit.sv =====
// Gain-scheduled LQR state feedback unit, top level.
// Usage:
//   in_ch  (sink): strut_len Q0.16, side_sel, feedback_0..5 Q16.16; a transaction
//          moves when valid and ready are both high at a rising clk edge.
//   out_ch (source): drive_0, drive_1 (Q16.16, saturated) and side_tag, one
//          transaction per input transaction, in order.
// The back end runs the 12 gain cubics and products on three shared lanes over
//   four phases and may accept the next transaction in its last phase.
// The front end and a QUEUE_DEPTH-entry queue take new transactions while the
//   back end works; results wait in an OUT_DEPTH-entry output queue.
// Receiver stall: results hold in the output queue; the back end starts a new
//   transaction only with a free output slot reserved, and then in_ch.ready drops
//   once front and queue fill. No result is dropped.
// Reset: rst_n synchronous, active low; empties all queues and pipelines.
// Depends on glf_pkg, glf_if, glf_front, glf_fifo, glf_back.
`timescale 1ns / 1ps
module gain_scheduled_lqr_feedback_unit #(
  parameter int QUEUE_DEPTH = 2,
  parameter int OUT_DEPTH   = 4
) (
  input logic        clk,
  input logic        rst_n,
  glf_in_if.sink     in_ch,
  glf_out_if.source  out_ch
);

  logic           fq_valid;
  logic           fq_ready;
  glf_pkg::item_t fq_item;
  logic           bq_valid;
  logic           bq_ready;
  glf_pkg::item_t bq_item;
  logic           res_valid;
  logic           res_ready;
  glf_pkg::res_t  res_data;
  glf_pkg::res_t  out_data;
  logic           out_pop;

  glf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_item  (fq_item)
  );

  glf_fifo #(
    .WIDTH ($bits(glf_pkg::item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_item),
    .rd_valid (bq_valid),
    .rd_ready (bq_ready),
    .rd_data  (bq_item)
  );

  glf_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (bq_valid),
    .q_ready   (bq_ready),
    .q_item    (bq_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .out_pop   (out_pop)
  );

  glf_fifo #(
    .WIDTH ($bits(glf_pkg::res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (res_valid),
    .wr_ready (res_ready),
    .wr_data  (res_data),
    .rd_valid (out_ch.valid),
    .rd_ready (out_ch.ready),
    .rd_data  (out_data)
  );

  assign out_pop         = out_ch.valid && out_ch.ready;
  assign out_ch.drive_0  = out_data.drive_0;
  assign out_ch.drive_1  = out_data.drive_1;
  assign out_ch.side_tag = out_data.side_tag;

endmodule
